// ===== design/tga_pkg.sv =====
package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_PKT_HDR,
    PH_PKT_DATA,
    PH_DONE
  } phase_t;

  // image kind as learned from the type byte
  localparam logic [1:0] KIND_COLOR    = 2'd0;
  localparam logic [1:0] KIND_ALPHA    = 2'd1;
  localparam logic [1:0] KIND_RLE      = 2'd2;
  localparam logic [1:0] KIND_MISMATCH = 2'd3;

  localparam logic [1:0] RES_HEADER = 2'd0;
  localparam logic [1:0] RES_PIXEL  = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TYPE      = 3'd1;
  localparam logic [2:0] ERR_SIZE      = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic [1:0] FMT_RGB24  = 2'd0;
  localparam logic [1:0] FMT_RGBA32 = 2'd1;
  localparam logic [1:0] FMT_ALPHA8 = 2'd2;

  localparam logic [7:0] TYPE_COLOR = 8'd2;
  localparam logic [7:0] TYPE_ALPHA = 8'd3;
  localparam logic [7:0] TYPE_RLE   = 8'd10;
  localparam int unsigned HEADER_LEN = 12;

  // classified input beat
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_zero;
    logic [1:0] type_kind;
    logic [2:0] bpp;
    logic       is_run;
    logic [7:0] count;
  } beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  fmt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_cnt;
    logic        last;
  } result_t;

  function automatic logic [1:0] fmt_code(input logic [1:0] ikind, input logic [2:0] bpp);
    logic [1:0] f;
    if (ikind == KIND_ALPHA) f = FMT_ALPHA8;
    else if (bpp == 3'd4) f = FMT_RGBA32;
    else f = FMT_RGB24;
    return f;
  endfunction

endpackage

// ===== design/tga_image_stream_decoder.sv =====
// channel  dir  tdata                          tuser        tlast
// s_axis   in   [7:0] data_byte                -            end_of_file
// m_axis   out  error_code .. repeat_res (80b) result_kind  last_pixel
//
// One byte beat per cycle in while the queue has room, at most one result per cycle out; a run leaves as one result.
// From input beat to result the path is a two-entry queue, then the decoder state machine
// and its output register.
// rst is synchronous and returns the decoder to header parsing with both channels empty.
// Input and output stall independently; the queue absorbs a stalled result slot.
module tga_image_stream_decoder
  import tga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] error_code, [18:3] image_width, [34:19] image_height, [36:35] pixel_format,
  // [44:37] red, [52:45] green, [60:53] blue, [68:61] alpha, [76:69] repeat_res
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast    // last_pixel
);

  beat_t   fbeat;
  beat_t   qbeat;
  logic    q_full;
  logic    q_valid;
  logic    take;
  result_t res;

  tga_front u_front (
    .data_byte   (s_tdata),
    .end_of_file (s_tlast),
    .beat        (fbeat)
  );

  assign s_tready = !q_full;

  tga_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_data (fbeat),
    .full      (q_full),
    .pop       (take),
    .not_empty (q_valid),
    .pop_data  (qbeat)
  );

  tga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_beat   (qbeat),
    .in_take   (take),
    .out_valid (m_tvalid),
    .out_res   (res),
    .out_ready (m_tready)
  );

  assign m_tdata = {3'd0, res.repeat_cnt, res.alpha, res.blue, res.green, res.red,
                    res.fmt, res.height, res.width, res.err};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// ===== design/tga_front.sv =====
module tga_front
  import tga_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output beat_t      beat
);

  always_comb begin
    beat.data    = data_byte;
    beat.eof     = end_of_file;
    beat.is_zero = (data_byte == 8'd0);
    case (data_byte)
      TYPE_COLOR: beat.type_kind = KIND_COLOR;
      TYPE_ALPHA: beat.type_kind = KIND_ALPHA;
      TYPE_RLE:   beat.type_kind = KIND_RLE;
      default:    beat.type_kind = KIND_MISMATCH;
    endcase
    case (data_byte)
      8'd8:    beat.bpp = 3'd1;
      8'd24:   beat.bpp = 3'd3;
      8'd32:   beat.bpp = 3'd4;
      default: beat.bpp = 3'd0;
    endcase
    // packet header: top bit marks a run, low bits hold count minus one
    beat.is_run = data_byte[7];
    beat.count  = {1'b0, data_byte[6:0]} + 8'd1;
  end

endmodule

// ===== design/tga_fifo.sv =====
module tga_fifo
  import tga_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  beat_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output beat_t pop_data
);

  beat_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/tga_back.sv =====
module tga_back
  import tga_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  beat_t   in_beat,
  output logic    in_take,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  phase_t      phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic [1:0]  image_kind, image_kind_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [2:0]  pixel_bytes, pixel_bytes_next;
  logic [31:0] pixel_total, pixel_total_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [7:0]  color_bytes [4];
  logic [7:0]  cb [4];
  logic        cb_we;
  logic        res_valid;
  result_t     res;
  logic        slot_free;
  logic [1:0]  bip_inc;
  logic [7:0]  cnt;
  logic [32:0] done_sum;
  logic        ok;

  assign slot_free = !out_valid || out_ready;
  assign in_take   = in_valid && slot_free;

  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    image_kind_next    = image_kind;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    pixel_bytes_next   = pixel_bytes;
    pixel_total_next   = pixel_total;
    pixels_done_next   = pixels_done;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    byte_in_pixel_next = byte_in_pixel;
    cb_we              = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    res.repeat_cnt     = 8'd1;
    ok                 = 1'b0;
    cnt                = 8'd1;
    done_sum           = '0;
    for (int k = 0; k < 4; k++) cb[k] = color_bytes[k];
    cb[byte_in_pixel] = in_beat.data;
    bip_inc = byte_in_pixel + 2'd1;

    if (in_take) begin
      if (in_beat.eof) begin
        if (phase != PH_DONE) begin
          res_valid = 1'b1;
          res.kind  = RES_ERROR;
          res.err   = ERR_TRUNCATED;
        end
        phase_next         = PH_HEADER;
        header_index_next  = 5'd0;
        image_kind_next    = KIND_COLOR;
        byte_in_pixel_next = 2'd0;
        packet_left_next   = 8'd0;
      end else begin
        case (phase)
          PH_HEADER: begin
            header_index_next = header_index + 5'd1;
            if (header_index < 5'(HEADER_LEN)) begin
              if (header_index == 5'd2) begin
                if (image_kind != KIND_MISMATCH) image_kind_next = in_beat.type_kind;
              end else if (!in_beat.is_zero) begin
                image_kind_next = KIND_MISMATCH;
              end
              if (header_index == 5'(HEADER_LEN - 1) && image_kind_next == KIND_MISMATCH) begin
                res_valid  = 1'b1;
                res.kind   = RES_ERROR;
                res.err    = ERR_TYPE;
                phase_next = PH_DONE;
              end
            end else if (header_index == 5'd12) begin
              width_reg_next = {8'd0, in_beat.data};
            end else if (header_index == 5'd13) begin
              width_reg_next = {in_beat.data, width_reg[7:0]};
            end else if (header_index == 5'd14) begin
              height_reg_next = {8'd0, in_beat.data};
            end else if (header_index == 5'd15) begin
              height_reg_next = {in_beat.data, height_reg[7:0]};
            end else if (header_index == 5'd16) begin
              pixel_bytes_next = in_beat.bpp;
            end else begin
              ok = (width_reg != 16'd0) && (height_reg != 16'd0);
              if (image_kind == KIND_ALPHA) ok = ok && (pixel_bytes == 3'd1);
              else ok = ok && (pixel_bytes == 3'd3 || pixel_bytes == 3'd4);
              res_valid = 1'b1;
              if (!ok) begin
                res.kind   = RES_ERROR;
                res.err    = ERR_SIZE;
                phase_next = PH_DONE;
              end else begin
                pixel_total_next   = width_reg * height_reg;
                pixels_done_next   = 32'd0;
                byte_in_pixel_next = 2'd0;
                packet_left_next   = 8'd0;
                packet_is_run_next = 1'b0;
                phase_next = (image_kind == KIND_RLE) ? PH_PKT_HDR : PH_PIXELS;
                res.kind   = RES_HEADER;
                res.width  = width_reg;
                res.height = height_reg;
                res.fmt    = fmt_code(image_kind, pixel_bytes);
              end
            end
          end
          PH_PIXELS, PH_PKT_DATA: begin
            cb_we              = 1'b1;
            byte_in_pixel_next = bip_inc;
            if (!({1'b0, bip_inc} < pixel_bytes && bip_inc != 2'd0)) begin
              byte_in_pixel_next = 2'd0;
              if (phase == PH_PKT_DATA) begin
                if (packet_is_run) begin
                  cnt              = packet_left;
                  phase_next       = PH_PKT_HDR;
                  packet_left_next = 8'd0;
                end else begin
                  packet_left_next = packet_left - 8'd1;
                  if (packet_left == 8'd1) phase_next = PH_PKT_HDR;
                end
              end
              res_valid      = 1'b1;
              res.kind       = RES_PIXEL;
              res.width      = width_reg;
              res.height     = height_reg;
              res.fmt        = fmt_code(image_kind, pixel_bytes);
              res.repeat_cnt = cnt;
              if (image_kind == KIND_ALPHA) begin
                res.alpha = cb[0];
              end else begin
                res.red   = cb[2];
                res.green = cb[1];
                res.blue  = cb[0];
                res.alpha = (pixel_bytes == 3'd4) ? cb[3] : 8'd0;
              end
              done_sum         = {1'b0, pixels_done} + {25'd0, cnt};
              pixels_done_next = done_sum[31:0];
              if (done_sum[31:0] >= pixel_total) begin
                res.last   = 1'b1;
                phase_next = PH_DONE;
              end
            end
          end
          PH_PKT_HDR: begin
            done_sum = {1'b0, pixels_done} + {25'd0, in_beat.count};
            if (done_sum > {1'b0, pixel_total}) begin
              res_valid  = 1'b1;
              res.kind   = RES_ERROR;
              res.err    = ERR_OVERFLOW;
              phase_next = PH_DONE;
            end else begin
              packet_left_next   = in_beat.count;
              packet_is_run_next = in_beat.is_run;
              byte_in_pixel_next = 2'd0;
              phase_next         = PH_PKT_DATA;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cb_we) color_bytes[byte_in_pixel] <= in_beat.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_index  <= 5'd0;
      image_kind    <= KIND_COLOR;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      pixel_bytes   <= 3'd0;
      pixel_total   <= 32'd0;
      pixels_done   <= 32'd0;
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      byte_in_pixel <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      image_kind    <= image_kind_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      pixel_bytes   <= pixel_bytes_next;
      pixel_total   <= pixel_total_next;
      pixels_done   <= pixels_done_next;
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_in_pixel <= byte_in_pixel_next;
      if (slot_free) out_valid <= in_take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) out_res <= res;
  end

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.last |-> out_res.kind == RES_PIXEL)
    else $error("last flag on a non-pixel result");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS || phase == PH_PKT_HDR || phase == PH_PKT_DATA)
      |-> pixels_done < pixel_total)
    else $error("pixel count passed total while image open");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_error_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == RES_ERROR |-> out_res.repeat_cnt == 8'd1 && !out_res.last)
    else $error("malformed error result");

endmodule

// ===== dv/tga_image_stream_decoder_tb.sv =====
module tga_image_stream_decoder_tb;
  import tga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  fmt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  rpt;
    logic        last;
  } tga_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } tga_byte_t;

  // directed row: optional typed-in result for header/error checks
  typedef struct {
    logic [7:0] data;
    logic       eof;
    bit         has_fixed;
    logic [1:0] fixed_kind;
    logic [2:0] fixed_err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  tga_image_stream_decoder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  phase_t      ph;
  logic [4:0]  hdr_idx;
  logic [1:0]  ikind;
  logic [15:0] wid, hgt;
  logic [2:0]  bpp;
  logic [31:0] px_total, px_done;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  byte_idx;
  logic [7:0]  cbytes [4];

  tga_res_t  expected_results [$];
  tga_byte_t file_bytes [$];
  dir_row_t  dir_rows [$];
  int errors = 0;
  int n_results = 0;
  int n_bytes_sent = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  bit pressure_done = 0;
  bit drain_done = 0;
  int fixed_checks = 0;

  function automatic logic [1:0] pix_fmt();
    if (ikind == KIND_ALPHA) return FMT_ALPHA8;
    return (bpp == 3'd4) ? FMT_RGBA32 : FMT_RGB24;
  endfunction

  function automatic tga_res_t make_res(logic [1:0] k, logic [2:0] e);
    tga_res_t r;
    r = '0;
    r.kind = k;
    r.err = e;
    r.rpt = 8'd1;
    if (k != RES_ERROR) begin
      r.width = wid;
      r.height = hgt;
      r.fmt = pix_fmt();
    end
    return r;
  endfunction

  function automatic tga_res_t emit_pixel(logic [7:0] cnt);
    tga_res_t r;
    r = make_res(RES_PIXEL, ERR_NONE);
    if (ikind == KIND_ALPHA) r.alpha = cbytes[0];
    else begin
      r.red = cbytes[2];
      r.green = cbytes[1];
      r.blue = cbytes[0];
      r.alpha = (bpp == 3'd4) ? cbytes[3] : 8'd0;
    end
    r.rpt = cnt;
    px_done = px_done + cnt;
    if (px_done >= px_total) begin
      r.last = 1'b1;
      ph = PH_DONE;
    end
    return r;
  endfunction

  function automatic void decoder_reset();
    ph = PH_HEADER; hdr_idx = '0; ikind = KIND_COLOR; wid = '0; hgt = '0; bpp = '0;
    px_total = '0; px_done = '0; pkt_left = '0; pkt_run = 1'b0; byte_idx = '0;
    for (int i = 0; i < 4; i++) cbytes[i] = '0;
  endfunction

  // returns 1 and fills r when the byte produces a result
  function automatic bit decode_byte(logic [7:0] b, logic eof, output tga_res_t r);
    logic [4:0] i;
    logic [8:0] cnt;
    bit ok;
    r = '0;
    if (eof) begin
      ok = (ph != PH_DONE);
      ph = PH_HEADER; hdr_idx = '0; ikind = KIND_COLOR; byte_idx = '0; pkt_left = '0;
      if (ok) r = make_res(RES_ERROR, ERR_TRUNCATED);
      return ok;
    end
    case (ph)
      PH_HEADER: begin
        i = hdr_idx;
        hdr_idx = hdr_idx + 5'd1;
        if (i < 12) begin
          if (i == 2) begin
            if (ikind != KIND_MISMATCH)
              ikind = (b == TYPE_COLOR) ? KIND_COLOR : (b == TYPE_ALPHA) ? KIND_ALPHA :
                      (b == TYPE_RLE) ? KIND_RLE : KIND_MISMATCH;
          end else if (b != 0) ikind = KIND_MISMATCH;
          if (i == 11 && ikind == KIND_MISMATCH) begin
            r = make_res(RES_ERROR, ERR_TYPE);
            ph = PH_DONE;
            return 1;
          end
          return 0;
        end
        if (i == 12) wid = {8'd0, b};
        else if (i == 13) wid[15:8] = b;
        else if (i == 14) hgt = {8'd0, b};
        else if (i == 15) hgt[15:8] = b;
        else if (i == 16) bpp = (b == 8 || b == 24 || b == 32) ? b[5:3] : 3'd0;
        else begin
          ok = wid != 0 && hgt != 0;
          if (ikind == KIND_ALPHA) ok = ok && bpp == 1;
          else ok = ok && (bpp == 3 || bpp == 4);
          if (!ok) begin
            r = make_res(RES_ERROR, ERR_SIZE);
            ph = PH_DONE;
            return 1;
          end
          px_total = wid * hgt;
          px_done = '0; byte_idx = '0; pkt_left = '0; pkt_run = 1'b0;
          ph = (ikind == KIND_RLE) ? PH_PKT_HDR : PH_PIXELS;
          r = make_res(RES_HEADER, ERR_NONE);
          return 1;
        end
        return 0;
      end
      PH_PIXELS, PH_PKT_DATA: begin
        cbytes[byte_idx] = b;
        byte_idx = byte_idx + 2'd1;
        if (byte_idx < bpp && byte_idx != 0) return 0;
        byte_idx = '0;
        if (ph == PH_PIXELS) begin
          r = emit_pixel(8'd1);
          return 1;
        end
        if (pkt_run) begin
          ph = PH_PKT_HDR;
          r = emit_pixel(pkt_left);
          pkt_left = '0;
          return 1;
        end
        pkt_left = pkt_left - 8'd1;
        if (pkt_left == 0) ph = PH_PKT_HDR;
        r = emit_pixel(8'd1);
        return 1;
      end
      PH_PKT_HDR: begin
        cnt = (b < 128) ? {1'b0, b} + 9'd1 : {1'b0, b} - 9'd127;
        if ({32'd0, px_done} + cnt > {32'd0, px_total}) begin
          r = make_res(RES_ERROR, ERR_OVERFLOW);
          ph = PH_DONE;
          return 1;
        end
        pkt_left = cnt[7:0];
        pkt_run = b[7];
        byte_idx = '0;
        ph = PH_PKT_DATA;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // file builders
  task automatic push_hdr(logic [7:0] typ, logic [15:0] w, logic [15:0] h, logic [7:0] d);
    for (int i = 0; i < 12; i++) file_bytes.push_back('{(i == 2) ? typ : 8'd0, 1'b0});
    file_bytes.push_back('{w[7:0], 1'b0});
    file_bytes.push_back('{w[15:8], 1'b0});
    file_bytes.push_back('{h[7:0], 1'b0});
    file_bytes.push_back('{h[15:8], 1'b0});
    file_bytes.push_back('{d, 1'b0});
    file_bytes.push_back('{8'($urandom), 1'b0});
  endtask

  task automatic push_eof();
    file_bytes.push_back('{8'($urandom), 1'b1});
  endtask

  task automatic build_random_file();
    int sel, w, h, d, bp, total, done, cnt, pk;
    logic [7:0] typ;
    sel = $urandom_range(0, 19);
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    if (sel < 5) begin typ = TYPE_COLOR; d = ($urandom_range(0, 1)) ? 32 : 24; end
    else if (sel < 8) begin typ = TYPE_ALPHA; d = 8; end
    else if (sel < 17) begin typ = TYPE_RLE; d = ($urandom_range(0, 1)) ? 32 : 24; end
    else if (sel == 17) begin typ = 8'($urandom); d = 24; end
    else begin
      typ = TYPE_COLOR; d = 8'($urandom);
      if ($urandom_range(0, 1)) w = 0;
    end
    // occasional big image for wide size fields, cut short by truncation
    if ($urandom_range(0, 40) == 0) begin w = 16'($urandom); h = 16'($urandom) | 1; end
    if ($urandom_range(0, 30) == 0) begin
      for (int i = 0; i < $urandom_range(1, 17); i++)
        file_bytes.push_back('{8'($urandom_range(0, 3) == 0 ? $urandom : 0), 1'b0});
      push_eof();
      return;
    end
    push_hdr(typ, 16'(w), 16'(h), 8'(d));
    bp = d / 8;
    total = w * h;
    if (total > 12) total = 12 + $urandom_range(0, 4);
    done = 0;
    while (done < total) begin
      if ($urandom_range(0, 60) == 0) break;
      if (typ == TYPE_RLE) begin
        cnt = $urandom_range(1, (total - done > 128) ? 128 : total - done);
        if ($urandom_range(0, 25) == 0) cnt = $urandom_range(1, 128);
        if ($urandom_range(0, 1)) begin
          pk = 128 + cnt - 1;
          file_bytes.push_back('{8'(pk), 1'b0});
          for (int j = 0; j < bp; j++) file_bytes.push_back('{8'($urandom), 1'b0});
        end else begin
          file_bytes.push_back('{8'(cnt - 1), 1'b0});
          for (int k = 0; k < cnt * bp; k++) file_bytes.push_back('{8'($urandom), 1'b0});
        end
        done += cnt;
      end else begin
        for (int j = 0; j < bp; j++) file_bytes.push_back('{8'($urandom), 1'b0});
        done++;
      end
    end
    for (int i = 0; i < $urandom_range(0, 2); i++)
      file_bytes.push_back('{8'($urandom), 1'b0});
    push_eof();
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(logic [7:0] b, logic eof);
    int g;
    tga_res_t r;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_byte(b, eof, r)) expected_results.push_back(r);
    n_bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_row(dir_row_t row);
    int g;
    tga_res_t r;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= row.data;
    s_tlast <= row.eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_byte(row.data, row.eof, r)) begin
      if (row.has_fixed && (r.kind != row.fixed_kind || r.err != row.fixed_err)) begin
        $display("%0t directed row: expected kind %0d err %0d, predictor kind %0d err %0d",
                 $time, row.fixed_kind, row.fixed_err, r.kind, r.err);
        errors++;
      end
      if (row.has_fixed) begin
        r.kind = row.fixed_kind;
        r.err = row.fixed_err;
        fixed_checks++;
      end
      expected_results.push_back(r);
    end else if (row.has_fixed) begin
      $display("%0t directed row: expected a result, predictor gives none", $time);
      errors++;
    end
    n_bytes_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(logic [7:0] d, logic e, bit f = 0, logic [1:0] k = 0,
                         logic [2:0] er = 0);
    dir_rows.push_back('{d, e, f, k, er});
  endtask

  // receiver
  initial begin
    tga_res_t got, exp_r;
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else begin
        g = gap_len();
        m_tready <= (g == 0);
        if (g > 0) begin
          repeat (g) @(negedge clk);
          m_tready <= 1'b1;
        end
        @(posedge clk);
        if (m_tvalid && m_tready) begin
          got = '{m_tuser, m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tdata[36:35],
                  m_tdata[44:37], m_tdata[52:45], m_tdata[60:53], m_tdata[68:61],
                  m_tdata[76:69], m_tlast};
          n_results++;
          if (expected_results.size() == 0) begin
            $display("%0t unexpected result: actual %h", $time, got);
            errors++;
          end else begin
            exp_r = expected_results.pop_front();
            if (got !== exp_r) begin
              $display("%0t result mismatch: expected %p actual %p", $time, exp_r, got);
              errors++;
            end
          end
        end
        @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    decoder_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // empty file, then unknown type, then end of file after the error
    add_row(8'h00, 1'b1, 1, RES_ERROR, ERR_TRUNCATED);
    for (int i = 0; i < 11; i++) add_row((i == 2) ? 8'hFF : 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1, RES_ERROR, ERR_TYPE);
    add_row(8'h00, 1'b1);
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    dir_rows.delete();
    // max-size RLE 32-bit header, zero height, tiny alpha image, run overflow, then a full run
    push_hdr(TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'd32);
    push_eof();
    push_hdr(TYPE_COLOR, 16'd1, 16'd0, 8'd24); push_eof();
    push_hdr(TYPE_ALPHA, 16'd1, 16'd1, 8'd8);
    file_bytes.push_back('{8'hFF, 1'b0}); push_eof();
    push_hdr(TYPE_RLE, 16'd1, 16'd2, 8'd24);
    file_bytes.push_back('{8'hFF, 1'b0}); push_eof();
    push_hdr(TYPE_RLE, 16'd128, 16'd1, 8'd32);
    file_bytes.push_back('{8'hFF, 1'b0});
    for (int j = 0; j < 4; j++) file_bytes.push_back('{8'hFF, 1'b0});
    file_bytes.push_back('{8'h00, 1'b0}); push_eof();
    while (file_bytes.size() > 0) begin
      tga_byte_t fb;
      fb = file_bytes.pop_front();
      send_beat(fb.data, fb.eof);
    end
    // random files
    while (n_bytes_sent < 1000) begin
      build_random_file();
      if (!drain_done || $urandom_range(0, 8) == 0) begin
        // wait for the pipe to drain
        drain_done = 1;
        s_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(negedge clk);
      end
      if (!pressure_done && n_bytes_sent > 400) begin
        pressure_done = 1;
        fork
          begin
            hold_off = 1;
            repeat (60) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      while (file_bytes.size() > 0) begin
        tga_byte_t fb;
        fb = file_bytes.pop_front();
        send_beat(fb.data, fb.eof);
      end
    end
    s_tvalid <= 1'b0;
    stim_done = 1;
    while (expected_results.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d byte beats over many TGA files, checked %0d results (%0d typed in).",
             n_bytes_sent, n_results, fixed_checks);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
